[hw/rtl/kst_pkg.sv]
// kst_pkg: shared types and constants for the knob-set countdown timer
// no dependencies; imported by kst_step and knob_set_countdown_timer
package kst_pkg;

    // default parameter values
    localparam int MAX_MINUTES_DEF      = 99;
    localparam int TICKS_PER_SECOND_DEF = 1000;

    // fixed field widths of the ports
    localparam int REQ_W    = 2;
    localparam int DELTA_W  = 6;
    localparam int PHASE_W  = 2;
    localparam int MIN_W    = 7;
    localparam int SEC_W    = 6;
    localparam int REMAIN_W = 13;

    // time constants
    localparam int SEC_PER_MIN     = 60;
    localparam int MAX_SECONDS     = 59;
    localparam int INIT_MINUTES_RST = 5;

    // request kinds carried in req_type
    typedef enum logic [REQ_W-1:0] {
        REQ_KNOB  = 2'd0,
        REQ_SHORT = 2'd1,
        REQ_LONG  = 2'd2,
        REQ_TICK  = 2'd3
    } kst_req_t;

    // view phases
    typedef enum logic [PHASE_W-1:0] {
        PH_SET_MIN = 2'd0,
        PH_SET_SEC = 2'd1,
        PH_RUN     = 2'd2,
        PH_ABORT   = 2'd3
    } kst_phase_t;

    // one result item
    typedef struct packed {
        kst_phase_t          phase_now;
        logic [MIN_W-1:0]    minutes_set;
        logic [SEC_W-1:0]    seconds_set;
        logic                running;
        logic [REMAIN_W-1:0] remaining_seconds;
        logic                expired;
        logic                leave;
    } kst_result_t;

endpackage

[hw/rtl/knob_set_countdown_timer.sv]
// knob_set_countdown_timer: top level with input register, timer state and result register
// depends on kst_pkg and kst_step
//
// Countdown timer set with a rotary knob. Requests (knob turn, short press,
// long press, one tick) enter through in_valid/in_ready and each yields
// exactly one result on out_valid/out_ready. Throughput is one request per
// clock while the result side is not stalled; a request is held in the input
// register, then the whole state update is done in a single pass into the result
// register. in_ready stays high as long as the result register is empty or
// being taken, so stalls on the output side back up through at most two
// stages. initial_minutes is written through cfg_valid/cfg_ready (always
// ready) and takes effect at the next re-entry into minute setup.
module knob_set_countdown_timer #(
    parameter int MaxMinutes     = kst_pkg::MAX_MINUTES_DEF,
    parameter int TicksPerSecond = kst_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [kst_pkg::REQ_W-1:0]         req_type,
    input  logic signed [kst_pkg::DELTA_W-1:0] knob_delta,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [kst_pkg::PHASE_W-1:0]       phase_now,
    output logic [kst_pkg::MIN_W-1:0]         minutes_set,
    output logic [kst_pkg::SEC_W-1:0]         seconds_set,
    output logic                              running,
    output logic [kst_pkg::REMAIN_W-1:0]      remaining_seconds,
    output logic                              expired,
    output logic                              leave,
    // configuration channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kst_pkg::MIN_W-1:0]         initial_minutes
);
    import kst_pkg::*;

    localparam int MinBits  = $clog2(MaxMinutes + 1);
    localparam int MinRegW  = (MinBits > MIN_W) ? MinBits : MIN_W;
    localparam int MinTop   = (MaxMinutes > 127) ? MaxMinutes : 127;
    localparam int SecLeftW = $clog2(MinTop * SEC_PER_MIN + SEC_PER_MIN);
    localparam int MsW      = (TicksPerSecond > 1) ? $clog2(TicksPerSecond) : 1;

    // input register
    logic                   in_valid_reg;
    kst_req_t               req_reg;
    logic [DELTA_W-1:0]     delta_reg;

    // timer state
    logic [MIN_W-1:0]       init_min_reg;
    kst_phase_t             phase_reg;
    logic [MinRegW-1:0]     minutes_reg;
    logic [SEC_W-1:0]       seconds_reg;
    logic                   running_reg;
    logic [SecLeftW-1:0]    secs_left_reg;
    logic [MsW-1:0]         ms_left_reg;

    kst_phase_t             phase_next;
    logic [MinRegW-1:0]     minutes_next;
    logic [SEC_W-1:0]       seconds_next;
    logic                   running_next;
    logic [SecLeftW-1:0]    secs_left_next;
    logic [MsW-1:0]         ms_left_next;

    // result register
    logic                   out_valid_reg;
    kst_result_t            res_reg;
    kst_result_t            res_next;

    logic                   advance;

    // stage handshake
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    kst_step #(
        .MaxMinutes     (MaxMinutes),
        .TicksPerSecond (TicksPerSecond),
        .MinRegW        (MinRegW),
        .SecLeftW       (SecLeftW),
        .MsW            (MsW)
    ) u_step (
        .req            (req_reg),
        .knob_delta     (delta_reg),
        .init_minutes   (init_min_reg),
        .phase          (phase_reg),
        .minutes        (minutes_reg),
        .seconds        (seconds_reg),
        .running        (running_reg),
        .secs_left      (secs_left_reg),
        .ms_left        (ms_left_reg),
        .phase_next     (phase_next),
        .minutes_next   (minutes_next),
        .seconds_next   (seconds_next),
        .running_next   (running_next),
        .secs_left_next (secs_left_next),
        .ms_left_next   (ms_left_next),
        .result         (res_next)
    );

    // input register load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg   <= REQ_KNOB;
            delta_reg <= '0;
        end
        else if (in_valid && in_ready)
        begin
            req_reg   <= kst_req_t'(req_type);
            delta_reg <= knob_delta;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            init_min_reg <= MIN_W'(INIT_MINUTES_RST);
        else if (cfg_valid && cfg_ready)
            init_min_reg <= initial_minutes;
    end

    // timer state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SET_MIN;
            minutes_reg   <= MinRegW'(INIT_MINUTES_RST);
            seconds_reg   <= '0;
            running_reg   <= 1'b0;
            secs_left_reg <= '0;
            ms_left_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            minutes_reg   <= minutes_next;
            seconds_reg   <= seconds_next;
            running_reg   <= running_next;
            secs_left_reg <= secs_left_next;
            ms_left_reg   <= ms_left_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    // output fields
    assign out_valid         = out_valid_reg;
    assign phase_now         = res_reg.phase_now;
    assign minutes_set       = res_reg.minutes_set;
    assign seconds_set       = res_reg.seconds_set;
    assign running           = res_reg.running;
    assign remaining_seconds = res_reg.remaining_seconds;
    assign expired           = res_reg.expired;
    assign leave             = res_reg.leave;

`ifndef ASSERT_OFF
    // an idle timer holds no leftover count
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (secs_left_reg == '0 && ms_left_reg == '0))
        else $error("count left while not running");

    // tick count within one second
    a_ms_range: assert property (@(posedge clk) disable iff (!rst_n)
        ms_left_reg <= MsW'(TicksPerSecond - 1))
        else $error("tick count out of range");

    // expiry always ends the run
    a_expire_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.expired |-> !res_reg.running)
        else $error("expired while still running");

    // leaving without a run lands in minute setup
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.leave && !res_reg.running
        |-> res_reg.phase_now == PH_SET_MIN)
        else $error("re-entry without run not in minute setup");

    // a stalled request is not dropped
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(req_reg))
        else $error("stalled request lost");
`endif

endmodule

[hw/rtl/kst_step.sv]
// kst_step: next-state and result logic for one request of the timer
// depends on kst_pkg; instantiated by knob_set_countdown_timer
module kst_step #(
    parameter int MaxMinutes     = kst_pkg::MAX_MINUTES_DEF,
    parameter int TicksPerSecond = kst_pkg::TICKS_PER_SECOND_DEF,
    parameter int MinRegW        = kst_pkg::MIN_W,
    parameter int SecLeftW       = kst_pkg::REMAIN_W,
    parameter int MsW            = 10
) (
    input  kst_pkg::kst_req_t                  req,
    input  logic [kst_pkg::DELTA_W-1:0]        knob_delta,
    input  logic [kst_pkg::MIN_W-1:0]          init_minutes,
    input  kst_pkg::kst_phase_t                phase,
    input  logic [MinRegW-1:0]                 minutes,
    input  logic [kst_pkg::SEC_W-1:0]          seconds,
    input  logic                               running,
    input  logic [SecLeftW-1:0]                secs_left,
    input  logic [MsW-1:0]                     ms_left,
    output kst_pkg::kst_phase_t                phase_next,
    output logic [MinRegW-1:0]                 minutes_next,
    output logic [kst_pkg::SEC_W-1:0]          seconds_next,
    output logic                               running_next,
    output logic [SecLeftW-1:0]                secs_left_next,
    output logic [MsW-1:0]                     ms_left_next,
    output kst_pkg::kst_result_t               result
);
    import kst_pkg::*;

    localparam int SumW = MinRegW + 2;

    logic signed [SumW-1:0] min_sum;
    logic signed [7:0]      sec_sum;
    logic [SecLeftW-1:0]    start_secs;
    logic                   expired;
    logic                   leave;

    // knob sums and start value
    always_comb
    begin
        min_sum    = $signed({2'b00, minutes})
                   + $signed({{(SumW-DELTA_W){knob_delta[DELTA_W-1]}}, knob_delta});
        sec_sum    = $signed({2'b00, seconds})
                   + $signed({{(8-DELTA_W){knob_delta[DELTA_W-1]}}, knob_delta});
        start_secs = SecLeftW'(minutes) * SecLeftW'(SEC_PER_MIN) + SecLeftW'(seconds);
    end

    // request decode and state update
    always_comb
    begin
        phase_next     = phase;
        minutes_next   = minutes;
        seconds_next   = seconds;
        running_next   = running;
        secs_left_next = secs_left;
        ms_left_next   = ms_left;
        expired        = 1'b0;
        leave          = 1'b0;
        unique case (req)
            REQ_KNOB:
            begin
                if (phase == PH_SET_MIN)
                begin
                    if (min_sum < 0)
                        minutes_next = MinRegW'(MaxMinutes);
                    else if (min_sum > $signed(SumW'(MaxMinutes)))
                        minutes_next = '0;
                    else
                        minutes_next = min_sum[MinRegW-1:0];
                end
                else if (phase == PH_SET_SEC)
                begin
                    if (sec_sum < 0)
                        seconds_next = SEC_W'(MAX_SECONDS);
                    else if (sec_sum > $signed(8'(MAX_SECONDS)))
                        seconds_next = '0;
                    else
                        seconds_next = sec_sum[SEC_W-1:0];
                end
            end
            REQ_SHORT:
            begin
                unique case (phase)
                    PH_SET_MIN: phase_next = PH_SET_SEC;
                    PH_SET_SEC:
                    begin
                        if (minutes != '0 || seconds != '0)
                        begin
                            phase_next     = PH_RUN;
                            running_next   = 1'b1;
                            secs_left_next = start_secs;
                            ms_left_next   = '0;
                        end
                    end
                    PH_RUN: phase_next = PH_ABORT;
                    PH_ABORT:
                    begin
                        running_next   = 1'b0;
                        secs_left_next = '0;
                        ms_left_next   = '0;
                        phase_next     = PH_SET_MIN;
                    end
                endcase
            end
            REQ_LONG:
            begin
                if (phase == PH_ABORT)
                    phase_next = PH_RUN;
                else if (phase == PH_SET_SEC)
                    phase_next = PH_SET_MIN;
                else
                begin
                    // leave and re-enter
                    leave = 1'b1;
                    if (running)
                        phase_next = PH_RUN;
                    else
                    begin
                        phase_next   = PH_SET_MIN;
                        minutes_next = MinRegW'(init_minutes);
                        seconds_next = '0;
                    end
                end
            end
            REQ_TICK:
            begin
                if (running)
                begin
                    if (ms_left != '0)
                        ms_left_next = ms_left - 1'b1;
                    else if (secs_left != '0)
                    begin
                        secs_left_next = secs_left - 1'b1;
                        ms_left_next   = MsW'(TicksPerSecond - 1);
                    end
                    // count reached zero
                    if (secs_left_next == '0 && ms_left_next == '0)
                    begin
                        running_next   = 1'b0;
                        secs_left_next = '0;
                        ms_left_next   = '0;
                        expired        = 1'b1;
                        if (phase == PH_RUN)
                        begin
                            leave        = 1'b1;
                            phase_next   = PH_SET_MIN;
                            minutes_next = MinRegW'(init_minutes);
                            seconds_next = '0;
                        end
                    end
                end
            end
        endcase
    end

    // result fields from the updated state
    always_comb
    begin
        result.phase_now         = phase_next;
        result.minutes_set       = minutes_next[MIN_W-1:0];
        result.seconds_set       = seconds_next;
        result.running           = running_next;
        result.remaining_seconds = running_next ? secs_left_next[REMAIN_W-1:0] : '0;
        result.expired           = expired;
        result.leave             = leave;
    end

endmodule
